/* design/rne_pkg.sv */
// Shared types and constants for the Roman numeral encoder.
`timescale 1ns / 1ps
`default_nettype none

package rne_pkg;

    // Decimal places handled: units up to ten thousands
    localparam int DIGIT_COUNT = 5;
    localparam int PLACE_W     = 3;

    // Input values at or above this limit are rejected
    localparam logic [15:0] VALUE_LIMIT = 16'd40000;

    // Divide by ten: q = (w * RECIP_TEN) >> RECIP_SHIFT, exact for 16-bit w
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // Symbol codes
    localparam logic [3:0] SYM_NONE = 4'd0;

    // Classification of one request
    typedef enum logic [1:0] {
        KIND_NUM  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_OOR  = 2'd2
    } kind_t;

    // Queue entry: classification and decimal digits, index 0 is units
    typedef struct packed {
        kind_t                         kind;
        logic [DIGIT_COUNT-1:0][3:0]   digits;
    } entry_t;

endpackage

`default_nettype wire

/* design/rne_front.sv */
// Front end: accepts a value, classifies it and splits it into decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module rne_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       value,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output rne_pkg::entry_t        push_entry
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                                       state_reg, state_next;
    logic [2:0]                                    cnt_reg, cnt_next;
    logic [15:0]                                   work_reg, work_next;
    rne_pkg::kind_t                                kind_reg, kind_next;
    logic [rne_pkg::DIGIT_COUNT-1:0][3:0]          digits_reg, digits_next;

    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] quot_x10;
    logic [3:0]  digit;

    // Divide the working value by ten through the reciprocal
    assign prod     = 32'(work_reg) * 32'(rne_pkg::RECIP_TEN);
    assign quot     = 13'(prod >> rne_pkg::RECIP_SHIFT);
    assign quot_x10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    assign digit    = 4'(work_reg - quot_x10);

    assign in_ready        = (state_reg == F_IDLE);
    assign push_valid      = (state_reg == F_PUSH);
    assign push_entry.kind   = kind_reg;
    assign push_entry.digits = digits_reg;

    // Sequence: take request, peel off one digit per cycle, hand to queue
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        work_next   = work_reg;
        kind_next   = kind_reg;
        digits_next = digits_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    work_next = value;
                    cnt_next  = 3'd0;
                    if (value >= rne_pkg::VALUE_LIMIT)
                    begin
                        kind_next  = rne_pkg::KIND_OOR;
                        state_next = F_PUSH;
                    end
                    else if (value == 16'd0)
                    begin
                        kind_next  = rne_pkg::KIND_ZERO;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        kind_next  = rne_pkg::KIND_NUM;
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                work_next   = 16'(quot);
                digits_next = {digit, digits_reg[rne_pkg::DIGIT_COUNT-1:1]};
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'(rne_pkg::DIGIT_COUNT - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        kind_reg   <= kind_next;
        digits_reg <= digits_next;
    end

endmodule

`default_nettype wire

/* design/rne_queue.sv */
// Two-entry queue between the digit front end and the symbol back end.
`timescale 1ns / 1ps
`default_nettype none

module rne_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire rne_pkg::entry_t   push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output rne_pkg::entry_t        pop_entry
);

    rne_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* design/rne_back.sv */
// Back end: expands queued digits into symbol results, one per cycle while the output slot is free.
`timescale 1ns / 1ps
`default_nettype none

module rne_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire rne_pkg::entry_t   pop_entry,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [3:0]             symbol,
    output logic                   last,
    output logic                   out_of_range
);

    typedef enum logic [1:0] {
        B_LOAD = 2'b01,
        B_EMIT = 2'b10
    } bstate_t;

    localparam int DC = rne_pkg::DIGIT_COUNT;

    bstate_t                    state_reg, state_next;
    rne_pkg::kind_t             kind_reg, kind_next;
    logic [DC-1:0][3:0]         digits_reg, digits_next;
    logic [DC-1:0]              mask_reg, mask_next;
    logic [1:0]                 step_reg, step_next;

    logic                       out_valid_reg, out_valid_next;
    logic [3:0]                 sym_reg, sym_next;
    logic                       last_reg, last_next;
    logic                       oor_reg, oor_next;

    logic                       slot_free;
    logic [rne_pkg::PLACE_W-1:0] place;
    logic [3:0]                 dig;
    logic [2:0]                 len;
    logic [3:0]                 sym_one, sym_five, sym_ten, sym_cur;
    logic                       digit_done;
    logic [DC-1:0]              mask_rest;

    // Number of symbols one digit needs
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        n = 3'd0;
        case (d) inside
            [4'd1:4'd3]:      n = 3'(d);
            4'd4, 4'd9:       n = 3'd2;
            [4'd5:4'd8]:      n = 3'(d - 4'd4);
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // Find the most significant place still holding a nonzero digit
    always_comb
    begin
        place = '0;
        for (int i = 0; i < DC; i++)
        begin
            if (mask_reg[i])
            begin
                place = rne_pkg::PLACE_W'(i);
            end
        end
    end

    assign dig       = digits_reg[place];
    assign len       = digit_len(dig);
    assign sym_one   = 4'({place, 1'b0}) + 4'd1;
    assign sym_five  = 4'({place, 1'b0}) + 4'd2;
    assign sym_ten   = 4'({place, 1'b0}) + 4'd3;
    assign digit_done = (3'(step_reg) == len - 3'd1);
    assign mask_rest = mask_reg & ~(DC'(1) << place);

    // Pick the symbol for the current step of the digit
    always_comb
    begin
        sym_cur = sym_one;
        if (dig == 4'd9)
        begin
            sym_cur = (step_reg == 2'd0) ? sym_one : sym_ten;
        end
        else if (dig == 4'd4)
        begin
            sym_cur = (step_reg == 2'd0) ? sym_one : sym_five;
        end
        else if (dig >= 4'd5)
        begin
            sym_cur = (step_reg == 2'd0) ? sym_five : sym_one;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == B_LOAD);

    // Load an entry, then drive one symbol into the output slot per cycle while the slot is free
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        digits_next    = digits_reg;
        mask_next      = mask_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sym_next       = sym_reg;
        last_next      = last_reg;
        oor_next       = oor_reg;
        unique case (state_reg)
            B_LOAD:
            begin
                if (pop_valid)
                begin
                    kind_next   = pop_entry.kind;
                    digits_next = pop_entry.digits;
                    for (int i = 0; i < DC; i++)
                    begin
                        mask_next[i] = (pop_entry.digits[i] != 4'd0);
                    end
                    step_next  = 2'd0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (kind_reg != rne_pkg::KIND_NUM)
                    begin
                        sym_next   = rne_pkg::SYM_NONE;
                        last_next  = 1'b1;
                        oor_next   = (kind_reg == rne_pkg::KIND_OOR);
                        state_next = B_LOAD;
                    end
                    else
                    begin
                        sym_next  = sym_cur;
                        oor_next  = 1'b0;
                        last_next = digit_done && (mask_rest == '0);
                        if (digit_done)
                        begin
                            mask_next = mask_rest;
                            step_next = 2'd0;
                            if (mask_rest == '0)
                            begin
                                state_next = B_LOAD;
                            end
                        end
                        else
                        begin
                            step_next = step_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_LOAD;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            step_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            step_reg      <= step_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        digits_reg <= digits_next;
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        oor_reg    <= oor_next;
    end

    assign out_valid    = out_valid_reg;
    assign symbol       = sym_reg;
    assign last         = last_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

/* design/roman_numeral_encoder.sv */
// Top level of the Roman numeral encoder: front end, queue and back end.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    value[15:0]
//   out      output     out_valid/out_ready  symbol[3:0], last, out_of_range
//
// The front end takes a request in F_IDLE, splits it into digits in F_DIV
// (one divide-by-ten multiplier), then queues it in F_PUSH; it takes no
// new request until the last one is queued. The back end loads an entry
// in B_LOAD, then emits its symbols in B_EMIT while the output slot is
// free. Zero and rejected values skip the split. rst_n clears all control state.
// A stalled output holds its result while the queue lets the front run on.
`timescale 1ns / 1ps
`default_nettype none

module roman_numeral_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       symbol,
    output logic             last,
    output logic             out_of_range
);

    logic            push_valid, push_ready;
    rne_pkg::entry_t push_entry;
    logic            pop_valid, pop_ready;
    rne_pkg::entry_t pop_entry;

    rne_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    rne_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    rne_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol       (symbol),
        .last         (last),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

/* dv/rne_checker.sv */
// Checker for the Roman numeral encoder: predicts each symbol run and compares it.
`timescale 1ns / 1ps
module rne_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [15:0] value,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [3:0]  symbol,
    input  wire logic        last,
    input  wire logic        out_of_range,
    output int               fail_count,
    output int               pending,
    output int               values_seen,
    output int               symbols_seen,
    output int               rejected_values,
    output int               longest_numeral
);

    // Each decimal place p uses one = I + 2p, five = one + 1, ten = one + 2
    localparam logic [3:0] SYM_I = 4'd1;

    typedef struct packed {
        logic [15:0] src;
        logic [3:0]  symbol;
        logic        last;
        logic        out_of_range;
    } numeral_sym_t;

    numeral_sym_t expected_symbols[$];
    int           run_len;

    // Queue one predicted symbol of the numeral for v
    function automatic void push_symbol(input logic [15:0] v, input logic [3:0] sym);
        numeral_sym_t s;
        s.src          = v;
        s.symbol       = sym;
        s.last         = 1'b0;
        s.out_of_range = 1'b0;
        expected_symbols.push_back(s);
    endfunction

    // Expand one request into its run of symbols, most significant place first
    function automatic void predict_numeral(input logic [15:0] v);
        numeral_sym_t s;
        int unsigned  weight;
        int unsigned  digit;
        int           place;
        logic [3:0]   one_sym;
        logic [3:0]   five_sym;
        logic [3:0]   ten_sym;
        if (v >= rne_pkg::VALUE_LIMIT || v == 16'd0)
        begin
            s.src          = v;
            s.symbol       = rne_pkg::SYM_NONE;
            s.last         = 1'b1;
            s.out_of_range = (v >= rne_pkg::VALUE_LIMIT);
            expected_symbols.push_back(s);
            return;
        end
        weight = 10000;
        for (place = rne_pkg::DIGIT_COUNT - 1; place >= 0; place--)
        begin
            digit    = (v / weight) % 10;
            one_sym  = SYM_I + 4'(2 * place);
            five_sym = one_sym + 4'd1;
            ten_sym  = one_sym + 4'd2;
            if (digit == 9)
            begin
                push_symbol(v, one_sym);
                push_symbol(v, ten_sym);
            end
            else if (digit == 4)
            begin
                push_symbol(v, one_sym);
                push_symbol(v, five_sym);
            end
            else
            begin
                if (digit >= 5)
                begin
                    push_symbol(v, five_sym);
                    digit = digit - 5;
                end
                repeat (digit) push_symbol(v, one_sym);
            end
            weight = weight / 10;
        end
        expected_symbols[expected_symbols.size() - 1].last = 1'b1;
    endfunction

    // Predict on each accepted request, compare each accepted symbol
    always @(posedge clk or negedge rst_n)
    begin
        numeral_sym_t exp_sym;
        if (!rst_n)
        begin
            expected_symbols.delete();
            run_len = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_numeral(value);
                values_seen++;
                if (value >= rne_pkg::VALUE_LIMIT)
                    rejected_values++;
            end
            if (out_valid && out_ready)
            begin
                symbols_seen++;
                run_len++;
                if (last)
                begin
                    if (run_len > longest_numeral)
                        longest_numeral = run_len;
                    run_len = 0;
                end
                if (expected_symbols.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected symbol, got sym=%0d last=%0b oor=%0b",
                             $time, symbol, last, out_of_range);
                end
                else
                begin
                    exp_sym = expected_symbols.pop_front();
                    if (symbol !== exp_sym.symbol || last !== exp_sym.last ||
                        out_of_range !== exp_sym.out_of_range)
                    begin
                        fail_count++;
                        $display("%0t: value %0d: expected sym=%0d last=%0b oor=%0b,",
                                 $time, exp_sym.src, exp_sym.symbol, exp_sym.last,
                                 exp_sym.out_of_range);
                        $display("    got sym=%0d last=%0b oor=%0b",
                                 symbol, last, out_of_range);
                    end
                end
            end
            pending = expected_symbols.size();
        end
    end

endmodule

/* dv/tb_roman_numeral_encoder.sv */
// Testbench top for the Roman numeral encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_roman_numeral_encoder;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 246;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;

    // Field extremes, every digit pattern, both rejects, the longest numeral
    localparam logic [15:0] CORNER_VALUES [24] = '{
        16'd0, 16'd1, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd44,
        16'd3888, 16'd3999, 16'd4000, 16'd4999, 16'd5000, 16'd9999, 16'd10000,
        16'd12345, 16'd14949, 16'd27444, 16'd38888, 16'd39998, 16'd39999,
        16'd40000, 16'd65535, 16'd30000
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [15:0] value        = 16'd0;
    logic        out_ready    = 1'b0;
    wire logic   in_ready;
    wire logic   out_valid;
    wire logic [3:0] symbol;
    wire logic   last;
    wire logic   out_of_range;

    int fail_count;
    int pending;
    int values_seen;
    int symbols_seen;
    int rejected_values;
    int longest_numeral;

    int cycles      = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int long_holds  = 0;
    int mode        = 0;
    int mode_left   = 0;
    int beat        = 0;

    roman_numeral_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol       (symbol),
        .last         (last),
        .out_of_range (out_of_range)
    );

    rne_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .symbol          (symbol),
        .last            (last),
        .out_of_range    (out_of_range),
        .fail_count      (fail_count),
        .pending         (pending),
        .values_seen     (values_seen),
        .symbols_seen    (symbols_seen),
        .rejected_values (rejected_values),
        .longest_numeral (longest_numeral)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall modes, plus two long hold-offs to back the block up
    always @(posedge clk)
    begin
        beat <= (beat == 2) ? 0 : beat + 1;
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ((long_holds == 0 && sent_count >= 60) ||
                 (long_holds == 1 && sent_count >= 180))
        begin
            out_ready  <= 1'b0;
            stall_left <= LONG_HOLD;
            long_holds <= long_holds + 1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      <= $urandom_range(0, 3);
                mode_left <= $urandom_range(10, 80);
            end
            else
                mode_left <= mode_left - 1;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (beat == 0);
            endcase
        end
    end

    // Pick a value: mostly valid numerals, some digit-heavy, some rejects and zeros
    function automatic logic [15:0] random_value();
        int unsigned composed;
        int          i;
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1, 2:    return 16'($urandom_range(40000, 65535));
            3, 4, 5, 6, 7, 8:
            begin
                composed = $urandom_range(0, 3);
                for (i = 0; i < rne_pkg::DIGIT_COUNT - 1; i++)
                    composed = composed * 10 + (($urandom_range(0, 2) == 0) ?
                               $urandom_range(7, 9) : $urandom_range(0, 9));
                return 16'(composed);
            end
            9, 10, 11, 12: return 16'($urandom_range(1, 99));
            default: return 16'($urandom_range(1, 39999));
        endcase
    endfunction

    // Offer one request, hold it until taken, then maybe idle before the next
    task automatic offer_value(input logic [15:0] v);
        int gap_len;
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count <= sent_count + 1;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap_len != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        else
            burst_left = burst_left - 1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_VALUES[i])
            offer_value(CORNER_VALUES[i]);
        repeat (RANDOM_ITEMS)
            offer_value(random_value());
        in_valid <= 1'b0;

        // Drain, then watch for stray symbols
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d values (%0d above range), %0d symbols checked",
                 values_seen, rejected_values, symbols_seen);
        $display("longest numeral %0d symbols, %0d long output hold-offs",
                 longest_numeral, long_holds);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
design/rne_pkg.sv
design/rne_front.sv
design/rne_queue.sv
design/rne_back.sv
design/roman_numeral_encoder.sv
dv/rne_checker.sv
dv/tb_roman_numeral_encoder.sv
